// ===== rtl/core/tsd_pkg.sv =====
// Shared types and constants for the tar stream deframer.
// Used by every module of the deframer core; depends on nothing else.
`default_nettype none

package tsd_pkg;

  localparam int unsigned SIZE_WIDTH = 36;
  localparam int unsigned OFFS_WIDTH = 9;

  localparam logic [OFFS_WIDTH-1:0] BLOCK_LAST       = 9'd511;
  localparam logic [OFFS_WIDTH-1:0] NAME_LEN         = 9'd100;
  localparam logic [OFFS_WIDTH-1:0] SIZE_FIELD_START = 9'd124;
  localparam logic [OFFS_WIDTH-1:0] SIZE_FIELD_END   = 9'd136;

  localparam int unsigned TDATA_WIDTH = ((SIZE_WIDTH + 8 + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_EOA     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef struct packed {
    logic                  digit_seen;
    logic                  stopped;
    logic [SIZE_WIDTH-1:0] acc;
  } size_state_t;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            data;
    logic [SIZE_WIDTH-1:0] size;
    logic                  last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/tsd_size_parser.sv =====
// Octal size field parser: next parse state for one size field byte.
// Depends on tsd_pkg.
`default_nettype none

module tsd_size_parser (
  input  var tsd_pkg::size_state_t cur_i,
  input  var logic [7:0]           byte_i,
  output tsd_pkg::size_state_t     nxt_o
);

  logic                           is_space;
  logic                           is_digit;
  logic [tsd_pkg::SIZE_WIDTH-1:0] shifted;

  assign is_space = (byte_i == 8'h20) || (byte_i >= 8'h09 && byte_i <= 8'h0d);
  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h37);
  assign shifted  = {cur_i.acc[tsd_pkg::SIZE_WIDTH-4:0], byte_i[2:0]};

  always_comb begin
    nxt_o = cur_i;
    if (!cur_i.stopped && !(!cur_i.digit_seen && is_space)) begin
      if (is_digit) begin
        nxt_o.digit_seen = 1'b1;
        if (cur_i.acc[tsd_pkg::SIZE_WIDTH-1 -: 3] != 3'b000) begin
          nxt_o.acc = '1;
        end else begin
          nxt_o.acc = shifted;
        end
      end else begin
        nxt_o.stopped = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tsd_deframer_step.sv =====
// Deframer state and the per-beat update: block tracking, name, size and payload.
// Depends on tsd_pkg and tsd_size_parser.
`default_nettype none

module tsd_deframer_step (
  input  var logic                 clk_i,
  input  var logic                 rst_ni,
  input  var logic                 step_i,
  input  var logic [7:0]           byte_i,
  output logic                     res_valid_o,
  output tsd_pkg::result_t         res_o
);

  tsd_pkg::phase_e                phase_q, phase_d;
  logic [tsd_pkg::OFFS_WIDTH-1:0] offs_q, offs_d;
  logic                           name_fin_q, name_fin_d;
  logic                           empty_q, empty_d;
  tsd_pkg::size_state_t           size_q, size_d, size_cur, size_nxt;
  logic [tsd_pkg::SIZE_WIDTH-1:0] remain_q, remain_d, remain_dec;

  assign remain_dec = remain_q - tsd_pkg::SIZE_WIDTH'(1);

  tsd_size_parser u_size (
    .cur_i  (size_cur),
    .byte_i (byte_i),
    .nxt_o  (size_nxt)
  );

  always_comb begin
    size_cur = size_q;
    if (offs_q == '0) begin
      size_cur = '0;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    offs_d      = offs_q;
    name_fin_d  = name_fin_q;
    empty_d     = empty_q;
    size_d      = size_q;
    remain_d    = remain_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = tsd_pkg::KIND_NAME;
    unique case (phase_q)
      tsd_pkg::PH_HEADER: begin
        offs_d = offs_q + tsd_pkg::OFFS_WIDTH'(1);
        if (offs_q == '0) begin
          name_fin_d = 1'b0;
          empty_d    = 1'b0;
        end
        size_d = size_cur;
        if (offs_q < tsd_pkg::NAME_LEN && !name_fin_d) begin
          if (byte_i == 8'h00) begin
            name_fin_d = 1'b1;
            if (offs_q == '0) begin
              empty_d = 1'b1;
            end
          end else if (!empty_d) begin
            res_valid_o = 1'b1;
            res_o.kind  = tsd_pkg::KIND_NAME;
            res_o.data  = byte_i;
          end
        end
        if (offs_q >= tsd_pkg::SIZE_FIELD_START && offs_q < tsd_pkg::SIZE_FIELD_END) begin
          size_d = size_nxt;
        end
        if (offs_q == tsd_pkg::BLOCK_LAST) begin
          res_valid_o = 1'b1;
          res_o.data  = '0;
          if (empty_d) begin
            res_o.kind = tsd_pkg::KIND_EOA;
            phase_d    = tsd_pkg::PH_DONE;
          end else begin
            res_o.kind = tsd_pkg::KIND_ENTRY;
            res_o.size = size_d.acc;
            remain_d   = size_d.acc;
            phase_d    = (size_d.acc != '0) ? tsd_pkg::PH_DATA : tsd_pkg::PH_HEADER;
          end
        end
      end
      tsd_pkg::PH_DATA: begin
        offs_d = offs_q + tsd_pkg::OFFS_WIDTH'(1);
        if (remain_q != '0) begin
          remain_d    = remain_dec;
          res_valid_o = 1'b1;
          res_o.kind  = tsd_pkg::KIND_PAYLOAD;
          res_o.data  = byte_i;
          res_o.last  = (remain_dec == '0);
        end
        if (offs_q == tsd_pkg::BLOCK_LAST && remain_d == '0) begin
          phase_d = tsd_pkg::PH_HEADER;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tsd_pkg::PH_HEADER;
      offs_q     <= '0;
      name_fin_q <= 1'b0;
      empty_q    <= 1'b0;
      size_q     <= '0;
      remain_q   <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      offs_q     <= offs_d;
      name_fin_q <= name_fin_d;
      empty_q    <= empty_d;
      size_q     <= size_d;
      remain_q   <= remain_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tsd_out_stage.sv =====
// Result register that holds one result beat until the sink takes it.
// Depends on tsd_pkg.
`default_nettype none

module tsd_out_stage (
  input  var logic             clk_i,
  input  var logic             rst_ni,
  input  var logic             load_i,
  input  var tsd_pkg::result_t res_i,
  input  var logic             ready_i,
  output logic                 free_o,
  output logic                 valid_o,
  output tsd_pkg::result_t     res_o
);

  logic             valid_q, valid_d;
  tsd_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tar_stream_deframer_core.sv =====
// Top level of the tar stream deframer: input register, deframer step and result register.
// Depends on tsd_pkg, tsd_deframer_step and tsd_out_stage.
`default_nettype none

// The core takes a tar archive one byte per beat and accepts a beat every cycle while
// the result side keeps up. Each byte passes an input register, the combinational update
// logic and a result register before its result is presented. Name bytes, an entry start
// with the parsed size, payload bytes (tlast on the final one) and an end-of-archive
// marker leave on the master side; padding and other header bytes give no beat, and all
// input after end of archive is consumed silently.

module tar_stream_deframer_core (
  input  var logic                             clk_i,
  input  var logic                             rst_ni,
  input  var logic                             s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  var logic [7:0]                       s_axis_tdata,   // archive_byte
  output logic                                 m_axis_tvalid,
  input  var logic                             m_axis_tready,
  output logic [tsd_pkg::TDATA_WIDTH-1:0]      m_axis_tdata,   // result_byte, entry_size, zeros
  output logic [1:0]                           m_axis_tuser,   // result_kind
  output logic                                 m_axis_tlast    // last_payload
);

  logic             in_valid_q, in_valid_d;
  logic [7:0]       in_byte_q;
  logic             step;
  logic             out_free;
  logic             res_valid;
  tsd_pkg::result_t res, out_res;

  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_valid_d    = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  tsd_deframer_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tsd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tdata = tsd_pkg::TDATA_WIDTH'({out_res.size, out_res.data});
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== rtl/core/tsd_checker.sv =====
// Port-level checker for the tar stream deframer core, bound to the top level.
// Depends on tsd_pkg and tar_stream_deframer_core.
`default_nettype none

module tsd_checker (
  input var logic                        clk_i,
  input var logic                        rst_ni,
  input var logic                        m_axis_tvalid,
  input var logic                        m_axis_tready,
  input var logic [tsd_pkg::TDATA_WIDTH-1:0] m_axis_tdata,
  input var logic [1:0]                  m_axis_tuser,
  input var logic                        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  a_last_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == tsd_pkg::KIND_PAYLOAD)
    else $error("tlast on a beat that is not a payload byte");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == tsd_pkg::KIND_ENTRY || m_axis_tuser == tsd_pkg::KIND_EOA)
      |-> m_axis_tdata[7:0] == 8'h00)
    else $error("byte field not zero on entry start or end of archive");

  a_eoa_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tuser == tsd_pkg::KIND_EOA |=> !m_axis_tvalid)
    else $error("result beat after end of archive");

endmodule

bind tar_stream_deframer_core tsd_checker u_tsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
